[sv/stit_pkg.sv]
// Shared types, sizes and codes for the sorted table insert and rank block.
package stit_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_FOUND    = 2'd2;
    localparam logic [1:0] ST_MISSING  = 2'd3;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] count_before;
        logic [5:0] count_after;
        logic [6:0] occupancy;
    } t_out_beat;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic               insert;
        logic               evaluate;
        logic signed [31:0] value;
    } t_cell_ctl;

    // What one cell hands to the next one up the chain.
    typedef struct packed {
        logic               valid;
        logic               ge;
        logic signed [31:0] value;
    } t_link;

endpackage

[sv/sorted_table_insert_and_rank.sv]
// Top level: sorted table of signed values with insert and rank query.
//
// Input channel: i_in_valid / o_in_stall carry one t_in_beat per beat.
// operation selects insert or query; value is a signed 32-bit number.
// Output channel: o_out_valid / i_out_stall carry one t_out_beat per item,
// in the order the items were taken.
// Each item passes three steps: capture of the beat; compare, in which
// all cells compare against the value in parallel (and shift on an
// insert); and encode, in which the rank encoder builds the result into
// the output register. A new beat is taken only after encode is done;
// o_in_stall is high while an item is in the chain.
// The output register holds a finished result while i_out_stall is high; a
// following item may be taken and compared meanwhile, but waits before the
// encode step until the output register is free.
// Reset empties the table at once: every cell's valid flag clears and the
// fill count returns to zero.  No clearing pass is needed.
// An insert into a full table leaves it unchanged and reports it dropped.
module sorted_table_insert_and_rank
    import stit_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_ENC
    } t_state;

    t_state             r_state;
    logic               r_op;
    logic signed [31:0] r_val;
    logic [CNT_W-1:0]   r_fill;
    logic               r_full_drop;
    logic               r_out_valid;
    t_out_beat          r_out_beat;

    t_cell_ctl              w_ctl;
    t_link                  w_link [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] w_less;
    logic [TABLE_DEPTH-1:0] w_match;
    logic [TABLE_DEPTH-1:0] w_valid;
    logic [CNT_W-1:0]       w_rank;
    logic                   w_found;
    logic                   w_in_acc;
    logic                   w_full;
    logic                   w_out_free;
    logic [CNT_W-1:0]       w_after;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = (r_fill == CNT_W'(TABLE_DEPTH));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_after    = r_fill - CNT_W'(1) - w_rank;

    assign w_ctl.insert   = (r_state == S_CMP) && (r_op == OP_INSERT) && !w_full;
    assign w_ctl.evaluate = (r_state == S_CMP);
    assign w_ctl.value    = r_val;

    // The slot below the bottom cell always reads as a smaller, valid entry.
    assign w_link[0].valid = 1'b1;
    assign w_link[0].ge    = 1'b0;
    assign w_link[0].value = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        stit_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_prev  (w_link[g]),
            .o_link  (w_link[g+1]),
            .o_less  (w_less[g]),
            .o_match (w_match[g])
        );
        assign w_valid[g] = w_link[g+1].valid;
    end

    stit_rank_enc u_rank_enc (
        .i_less  (w_less),
        .i_match (w_match),
        .o_rank  (w_rank),
        .o_found (w_found)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_ctl.insert) begin
                        r_fill <= r_fill + CNT_W'(1);
                    end
                    r_state <= S_ENC;
                end
                S_ENC: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op  <= i_in_beat.operation;
            r_val <= i_in_beat.value;
        end
        if (r_state == S_CMP) begin
            r_full_drop <= w_full;
        end
        if (r_state == S_ENC && w_out_free) begin
            r_out_beat.occupancy    <= 7'(r_fill);
            r_out_beat.count_before <= '0;
            r_out_beat.count_after  <= '0;
            if (r_op == OP_INSERT) begin
                r_out_beat.status <= r_full_drop ? ST_FULL : ST_INSERTED;
            end else if (w_found) begin
                r_out_beat.status       <= ST_FOUND;
                r_out_beat.count_before <= 6'(w_rank);
                r_out_beat.count_after  <= 6'(w_after);
            end else begin
                r_out_beat.status <= ST_MISSING;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(TABLE_DEPTH))
        else $error("fill count above table depth");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_fill))
        else $error("cell valid flags disagree with fill count");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_ENC)
        else $error("result appeared without an encode step");

    a_found_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status == ST_FOUND) |->
        6'(7'(o_out_beat.count_before) + 7'(o_out_beat.count_after) + 7'd1)
            == 6'(o_out_beat.occupancy))
        else $error("found counts do not add up to occupancy");

endmodule

[sv/stit_cell.sv]
// One slot of the sorted chain: holds an entry and shifts or loads on insert.
module stit_cell
    import stit_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_link     i_prev,
    output t_link     o_link,
    output logic      o_less,
    output logic      o_match
);

    logic               r_valid;
    logic signed [31:0] r_value;
    logic               r_less;
    logic               r_match;
    logic               w_less;
    logic               w_match;

    assign w_less  = r_valid && (r_value < i_ctl.value);
    assign w_match = r_valid && (r_value == i_ctl.value);

    assign o_link.valid = r_valid;
    assign o_link.ge    = !w_less;
    assign o_link.value = r_value;
    assign o_less       = r_less;
    assign o_match      = r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.insert && !w_less) begin
            r_valid <= r_valid | i_prev.valid;
        end
    end

    // Entries not below the new value move up one slot; the first of them takes the value.
    always_ff @(posedge i_clk) begin
        if (i_ctl.insert && !w_less) begin
            r_value <= i_prev.ge ? i_prev.value : i_ctl.value;
        end
        if (i_ctl.evaluate) begin
            r_less  <= w_less;
            r_match <= w_match;
        end
    end

endmodule

[sv/stit_rank_enc.sv]
// Turns the chain's thermometer of less-than flags into a rank and a hit flag.
module stit_rank_enc
    import stit_pkg::*;
(
    input  logic [TABLE_DEPTH-1:0] i_less,
    input  logic [TABLE_DEPTH-1:0] i_match,
    output logic [CNT_W-1:0]       o_rank,
    output logic                   o_found
);

    logic [TABLE_DEPTH+1:0] w_therm;
    logic [TABLE_DEPTH:0]   w_edge;
    logic [CNT_W-1:0]       w_rank;

    // The table is sorted and filled from the bottom, so the flags form a
    // run of ones; exactly one edge marks where the run ends.
    assign w_therm = {1'b0, i_less, 1'b1};

    always_comb begin
        w_rank = '0;
        for (int i = 0; i <= TABLE_DEPTH; i++) begin
            w_edge[i] = w_therm[i] & ~w_therm[i+1];
            w_rank    = w_rank | ({CNT_W{w_edge[i]}} & CNT_W'(i));
        end
    end

    assign o_rank  = w_rank;
    assign o_found = |i_match;

endmodule
